// ===== sv/flip_attitude_sequence_generator_defines.svh =====
// ---------------------------------------------------------------------------
// flip attitude sequence generator assertion macros
// shared helpers for the concurrent checks of the top level
// ---------------------------------------------------------------------------
`ifndef FLIP_ATTITUDE_SEQUENCE_GENERATOR_DEFINES_SVH
`define FLIP_ATTITUDE_SEQUENCE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define FASG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FASG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/fasg_pkg.sv =====
// ---------------------------------------------------------------------------
// fasg_pkg
// shared types and constants of the flip attitude sequence generator
// ---------------------------------------------------------------------------
package fasg_pkg;

   localparam int DEFAULT_PHASE_BITS = 24;
   localparam int DEFAULT_OUT_BITS   = 16;
   localparam int RATE_BITS          = 16;
   localparam int INDEX_BITS         = 16;
   localparam int CSR_INDEX_BITS     = 3;

   localparam int CORDIC_ITERS = 24;
   localparam logic signed [31:0] CORDIC_ONE = 32'sd652032874;

   localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROLL_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_ENABLE    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YAW_HALF_PHASE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_ANGLE_STEP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGULAR_RATE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_INDEX      = 3'd5;

   localparam int LANES = 3;
   localparam int MUL_STEPS = 12;
   localparam int STEP_BITS = 4;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         quad;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

// ===== sv/flip_attitude_sequence_generator.sv =====
// ---------------------------------------------------------------------------
// flip_attitude_sequence_generator
// attitude quaternion per control tick of a full roll/pitch flip
// ---------------------------------------------------------------------------
// One item is taken at a time. An item that yields a sample goes from accept
// to result as follows: the accepting edge runs the first of 24 cordic cells
// (all three angles side by side), then the quadrant mapping, 12 steps on the
// shared 32x32 multiplier and the load of the output register; the next item is
// taken on the following edge. A result still held by rsp_ready low stalls the
// next sample only in its final step. An idle advance with no restart gives no
// result. csr writes are taken in any cycle and belong in the gaps where no
// sample is in flight.
module flip_attitude_sequence_generator #(
   parameter int PHASE_BITS = fasg_pkg::DEFAULT_PHASE_BITS,
   parameter int OUT_BITS   = fasg_pkg::DEFAULT_OUT_BITS,
   localparam int CSR_DATA_BITS = (PHASE_BITS > 16) ? PHASE_BITS : 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fasg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [OUT_BITS-1:0]          rsp_quat_w,
   output logic signed [OUT_BITS-1:0]          rsp_quat_x,
   output logic signed [OUT_BITS-1:0]          rsp_quat_y,
   output logic signed [OUT_BITS-1:0]          rsp_quat_z,
   output logic [fasg_pkg::RATE_BITS-1:0]      rsp_roll_rate,
   output logic [fasg_pkg::RATE_BITS-1:0]      rsp_pitch_rate,
   output logic                                rsp_last
);

`include "flip_attitude_sequence_generator_defines.svh"

   localparam int RB = fasg_pkg::RATE_BITS;
   localparam int IB = fasg_pkg::INDEX_BITS;
   localparam int SH = 31 - OUT_BITS;
   localparam logic signed [33:0] OUT_HI = 34'sd1 <<< (OUT_BITS - 1);
   localparam logic signed [33:0] ROUND  = 34'sd1 <<< (SH - 1);

   // configuration
   logic                  roll_en_ff, pitch_en_ff;
   logic [PHASE_BITS-1:0] yaw_phase_ff, step_phase_ff;
   logic [RB-1:0]         rate_ff;
   logic [IB-1:0]         last_index_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_en_ff    <= 1'b0;
         pitch_en_ff   <= 1'b0;
         yaw_phase_ff  <= '0;
         step_phase_ff <= '0;
         rate_ff       <= '0;
         last_index_ff <= IB'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fasg_pkg::CSR_ROLL_ENABLE:     roll_en_ff    <= csr_wdata[0];
            fasg_pkg::CSR_PITCH_ENABLE:    pitch_en_ff   <= csr_wdata[0];
            fasg_pkg::CSR_YAW_HALF_PHASE:  yaw_phase_ff  <= csr_wdata[PHASE_BITS-1:0];
            fasg_pkg::CSR_HALF_ANGLE_STEP: step_phase_ff <= csr_wdata[PHASE_BITS-1:0];
            fasg_pkg::CSR_ANGULAR_RATE:    rate_ff       <= csr_wdata[RB-1:0];
            fasg_pkg::CSR_LAST_INDEX:      last_index_ff <= csr_wdata[IB-1:0];
            default: ;
         endcase
      end
   end

   // sequence state and control
   fasg_pkg::state_type state_ff, state_in;
   logic                running_ff;
   logic [IB-1:0]       index_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [fasg_pkg::STEP_BITS-1:0] step_ff, step_in;

   logic                  req_accept, launch, is_last;
   logic [IB-1:0]         index_eff;
   logic [PHASE_BITS-1:0] phase_eff, roll_ph, pitch_ph;
   logic                  out_load;

   logic                item_last_ff;
   logic [RB-1:0]       item_roll_rate_ff, item_pitch_rate_ff;

   logic                chain_valid [fasg_pkg::CORDIC_ITERS+1];
   fasg_pkg::lanes_type chain_lanes [fasg_pkg::CORDIC_ITERS+1];

   assign req_ready  = (state_ff == fasg_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign launch     = req_accept && (req_restart || running_ff);
   assign index_eff  = req_restart ? '0 : index_ff;
   assign phase_eff  = req_restart ? '0 : phase_ff;
   assign is_last    = (index_eff == last_index_ff);
   assign roll_ph    = (!is_last && roll_en_ff) ? phase_eff : '0;
   assign pitch_ph   = (!is_last && pitch_en_ff) ? phase_eff : '0;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      out_load = 1'b0;
      case (state_ff)
         fasg_pkg::ST_IDLE: begin
            if (launch) begin
               state_in = fasg_pkg::ST_CORDIC;
            end
         end
         fasg_pkg::ST_CORDIC: begin
            if (chain_valid[fasg_pkg::CORDIC_ITERS]) begin
               state_in = fasg_pkg::ST_MUL;
               step_in  = '0;
            end
         end
         fasg_pkg::ST_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == fasg_pkg::STEP_BITS'(fasg_pkg::MUL_STEPS - 1)) begin
               state_in = fasg_pkg::ST_DONE;
            end
         end
         fasg_pkg::ST_DONE: begin
            if (!rsp_valid || rsp_ready) begin
               out_load = 1'b1;
               state_in = fasg_pkg::ST_IDLE;
            end
         end
         default: state_in = fasg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fasg_pkg::ST_IDLE;
         step_ff    <= '0;
         running_ff <= 1'b0;
         index_ff   <= '0;
         phase_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (launch) begin
            running_ff <= !is_last;
            index_ff   <= index_eff + 1'b1;
            phase_ff   <= phase_eff + step_phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         item_last_ff       <= is_last;
         item_roll_rate_ff  <= (!is_last && roll_en_ff) ? rate_ff : '0;
         item_pitch_rate_ff <= (!is_last && pitch_en_ff) ? rate_ff : '0;
      end
   end

   // cordic chain
   function automatic fasg_pkg::lane_type lane_start(input logic [PHASE_BITS-1:0] ph);
      logic [31:0]        p;
      fasg_pkg::lane_type l;
      p      = 32'(ph) << (32 - PHASE_BITS);
      l.x    = fasg_pkg::CORDIC_ONE;
      l.y    = '0;
      l.z    = $signed({2'b00, p[29:0]});
      l.quad = p[31:30];
      return l;
   endfunction

   assign chain_valid[0]    = launch;
   assign chain_lanes[0][0] = lane_start(roll_ph);
   assign chain_lanes[0][1] = lane_start(pitch_ph);
   assign chain_lanes[0][2] = lane_start(yaw_phase_ff);

   for (genvar g = 0; g < fasg_pkg::CORDIC_ITERS; g++) begin : g_cell
      fasg_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_lanes  (chain_lanes[g]),
         .out_valid (chain_valid[g+1]),
         .out_lanes (chain_lanes[g+1])
      );
   end

   // quadrant mapping
   logic signed [31:0] cos_ff [fasg_pkg::LANES];
   logic signed [31:0] sin_ff [fasg_pkg::LANES];

   always_ff @(posedge clock) begin
      if (state_ff == fasg_pkg::ST_CORDIC && chain_valid[fasg_pkg::CORDIC_ITERS]) begin
         for (int i = 0; i < fasg_pkg::LANES; i++) begin
            case (chain_lanes[fasg_pkg::CORDIC_ITERS][i].quad)
               2'd0: begin
                  cos_ff[i] <= chain_lanes[fasg_pkg::CORDIC_ITERS][i].x;
                  sin_ff[i] <= chain_lanes[fasg_pkg::CORDIC_ITERS][i].y;
               end
               2'd1: begin
                  cos_ff[i] <= -chain_lanes[fasg_pkg::CORDIC_ITERS][i].y;
                  sin_ff[i] <= chain_lanes[fasg_pkg::CORDIC_ITERS][i].x;
               end
               2'd2: begin
                  cos_ff[i] <= -chain_lanes[fasg_pkg::CORDIC_ITERS][i].x;
                  sin_ff[i] <= -chain_lanes[fasg_pkg::CORDIC_ITERS][i].y;
               end
               default: begin
                  cos_ff[i] <= chain_lanes[fasg_pkg::CORDIC_ITERS][i].y;
                  sin_ff[i] <= -chain_lanes[fasg_pkg::CORDIC_ITERS][i].x;
               end
            endcase
         end
      end
   end

   // shared multiplier
   logic signed [31:0] cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [31:0] term_ff [8];
   logic signed [31:0] op_a, op_b, mul_q;
   logic signed [63:0] prod;

   always_comb begin
      case (step_ff)
         4'd0:    begin op_a = cos_ff[0]; op_b = cos_ff[1]; end
         4'd1:    begin op_a = sin_ff[0]; op_b = sin_ff[1]; end
         4'd2:    begin op_a = sin_ff[0]; op_b = cos_ff[1]; end
         4'd3:    begin op_a = cos_ff[0]; op_b = sin_ff[1]; end
         4'd4:    begin op_a = cc_ff;     op_b = cos_ff[2]; end
         4'd5:    begin op_a = ss_ff;     op_b = sin_ff[2]; end
         4'd6:    begin op_a = sc_ff;     op_b = cos_ff[2]; end
         4'd7:    begin op_a = cs_ff;     op_b = sin_ff[2]; end
         4'd8:    begin op_a = cs_ff;     op_b = cos_ff[2]; end
         4'd9:    begin op_a = sc_ff;     op_b = sin_ff[2]; end
         4'd10:   begin op_a = cc_ff;     op_b = sin_ff[2]; end
         default: begin op_a = ss_ff;     op_b = cos_ff[2]; end
      endcase
   end

   assign prod  = 64'(op_a) * 64'(op_b) + 64'sd536870912;
   assign mul_q = 32'(prod >>> 30);

   always_ff @(posedge clock) begin
      if (state_ff == fasg_pkg::ST_MUL) begin
         case (step_ff)
            4'd0:    cc_ff <= mul_q;
            4'd1:    ss_ff <= mul_q;
            4'd2:    sc_ff <= mul_q;
            4'd3:    cs_ff <= mul_q;
            default: term_ff[3'(step_ff - 4'd4)] <= mul_q;
         endcase
      end
   end

   // rounding, saturation and output register
   function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [32:0] s);
      logic signed [33:0] v;
      v = (34'(s) + ROUND) >>> SH;
      if (v > OUT_HI - 34'sd1) begin
         return OUT_BITS'(OUT_HI - 34'sd1);
      end else if (v < -OUT_HI) begin
         return OUT_BITS'(-OUT_HI);
      end
      return OUT_BITS'(v);
   endfunction

   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic [RB-1:0]              roll_rate_ff, pitch_rate_ff;
   logic                       last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         qw_ff         <= to_out(33'(term_ff[0]) + 33'(term_ff[1]));
         qx_ff         <= to_out(33'(term_ff[2]) - 33'(term_ff[3]));
         qy_ff         <= to_out(33'(term_ff[4]) + 33'(term_ff[5]));
         qz_ff         <= to_out(33'(term_ff[6]) - 33'(term_ff[7]));
         roll_rate_ff  <= item_roll_rate_ff;
         pitch_rate_ff <= item_pitch_rate_ff;
         last_ff       <= item_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_roll_rate  = roll_rate_ff;
   assign rsp_pitch_rate = pitch_rate_ff;
   assign rsp_last       = last_ff;

   // checks
   logic mul_last, last_out, rates_zero, chain_done;

   assign mul_last   = (state_ff == fasg_pkg::ST_MUL) &&
                       (step_ff == fasg_pkg::STEP_BITS'(fasg_pkg::MUL_STEPS - 1));
   assign last_out   = rsp_valid && rsp_last;
   assign rates_zero = (rsp_roll_rate == '0) && (rsp_pitch_rate == '0);
   assign chain_done = chain_valid[fasg_pkg::CORDIC_ITERS];

   `FASG_ASSERT_NOW(a_idle_chain_empty, clock, reset, req_ready, !chain_done)
   `FASG_ASSERT_NEXT(a_mul_to_done, clock, reset, mul_last, state_ff == fasg_pkg::ST_DONE)
   `FASG_ASSERT_NOW(a_last_zero_rates, clock, reset, last_out, rates_zero)
   `FASG_ASSERT_NEXT(a_launch_to_chain, clock, reset, launch, chain_valid[1])

endmodule

// ===== sv/fasg_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// fasg_cordic_cell
// one registered cordic rotation over the roll, pitch and yaw lanes
// ---------------------------------------------------------------------------
module fasg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  fasg_pkg::lanes_type in_lanes,
   output logic                out_valid,
   output fasg_pkg::lanes_type out_lanes
);

   logic                valid_ff;
   fasg_pkg::lanes_type lanes_ff;
   fasg_pkg::lanes_type lanes_in;

   always_comb begin
      for (int i = 0; i < fasg_pkg::LANES; i++) begin
         lanes_in[i].quad = in_lanes[i].quad;
         if (!in_lanes[i].z[31]) begin
            lanes_in[i].x = in_lanes[i].x - (in_lanes[i].y >>> STAGE);
            lanes_in[i].y = in_lanes[i].y + (in_lanes[i].x >>> STAGE);
            lanes_in[i].z = in_lanes[i].z - $signed(fasg_pkg::ATAN_TURN[STAGE]);
         end else begin
            lanes_in[i].x = in_lanes[i].x + (in_lanes[i].y >>> STAGE);
            lanes_in[i].y = in_lanes[i].y - (in_lanes[i].x >>> STAGE);
            lanes_in[i].z = in_lanes[i].z + $signed(fasg_pkg::ATAN_TURN[STAGE]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule
